@@ rtl/sps_pkg.sv @@
// Package for the servo pulse sequencer: channel count, codes and payload types.
// No dependencies; used by servo_pulse_sequencer_top.
`timescale 1ns / 1ps

package sps_pkg;

    // Number of servo channels held in the width table
    localparam int CHANNELS = 10;

    // Input transaction modes
    localparam logic [1:0] MODE_TICK  = 2'd0;
    localparam logic [1:0] MODE_WRITE = 2'd1;
    localparam logic [1:0] MODE_START = 2'd2;

    // Configuration register indexes
    localparam logic CFG_ACTIVE_CHANNELS = 1'b0;
    localparam logic CFG_CLOCK_SCALE     = 1'b1;

    // Clock scale codes
    localparam logic [1:0] SCALE_HALF   = 2'd0;
    localparam logic [1:0] SCALE_DOUBLE = 2'd1;

    // Interval lengths before scaling
    localparam logic [15:0] LEAD_GAP   = 16'd200;
    localparam logic [15:0] EMPTY_SLOT = 16'd100;

    // Reset values of the configuration registers
    localparam logic [3:0] ACTIVE_CHANNELS_RESET = 4'd8;
    localparam logic [1:0] CLOCK_SCALE_RESET     = 2'd2;

    typedef struct packed {
        logic [1:0]         mode;
        logic [3:0]         channel;
        logic signed [15:0] width;
    } sps_in_t;

    typedef struct packed {
        logic [CHANNELS-1:0] pins;
        logic                busy_res;
        logic [3:0]          current_channel;
        logic                frame_done;
    } sps_out_t;

endpackage

@@ rtl/servo_pulse_sequencer_top.sv @@
// Servo pulse sequencer top level: width table, frame timer and result register.
// Depends on sps_pkg for codes, constants and payload types.
//
//  channel   signals                          direction  carries
//  input     in_valid / in_ready / in_data    in         mode, channel, width
//  result    out_valid / out_ready / out_data out        pins, busy, channel, done
//  config    cfg_valid / cfg_ready /          in         register index, value
//            cfg_index / cfg_data
//
// One input transaction is taken per cycle; its result appears in the output
// register on the next cycle. Timer and width table updates happen in the same cycle as
// the accept, so the rate is set only by the single result register.
// A stalled result holds input ready low until it is taken.
// Reset (rst_n low, asynchronous) clears the width table, timer and pins,
// and loads active_channels = 8, clock_scale = 2. Configuration is always ready.
`timescale 1ns / 1ps

module servo_pulse_sequencer_top
    import sps_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  sps_in_t     in_data,
    output logic        out_valid,
    input  logic        out_ready,
    output sps_out_t    out_data,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [3:0]  cfg_data
);

    // Scale an interval length by the clock scale setting
    function automatic logic [15:0] scaled(input logic [15:0] x, input logic [1:0] sc);
        logic [15:0] v;
        begin
            if (sc == SCALE_HALF)
            begin
                v = {1'b0, x[15:1]};
            end
            else if (sc == SCALE_DOUBLE)
            begin
                v = x[15] ? 16'hFFFF : {x[14:0], 1'b0};
            end
            else
            begin
                v = x;
            end
            return v;
        end
    endfunction

    // One-hot pin mask for a channel number, empty for channel zero
    function automatic logic [CHANNELS-1:0] pin_bit(input logic [3:0] ch);
        logic [CHANNELS-1:0] m;
        begin
            for (int k = 0; k < CHANNELS; k++)
            begin
                m[k] = (ch == 4'(k + 1));
            end
            return m;
        end
    endfunction

    logic [15:0]         widths_reg [CHANNELS];
    logic [15:0]         tick_count_reg, tick_count_next;
    logic [15:0]         period_reg, period_next;
    logic [3:0]          chan_reg, chan_next;
    logic                running_reg, running_next;
    logic [CHANNELS-1:0] pins_reg, pins_next;
    logic [3:0]          active_reg;
    logic [1:0]          scale_reg;
    logic                out_valid_reg;
    sps_out_t            out_data_reg, out_data_next;
    logic                done;
    logic                accept;
    logic                write_en;
    logic [3:0]          write_idx;
    logic [4:0]          next_chan;
    logic                more_chans;
    logic [15:0]         next_width;

    assign in_ready  = !out_valid_reg || out_ready;
    assign accept    = in_valid && in_ready;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Decide whether the current interval is followed by another channel
    assign next_chan  = {1'b0, chan_reg} + 5'd1;
    assign more_chans = (next_chan <= {1'b0, active_reg}) && (next_chan <= 5'(CHANNELS));
    assign next_width = widths_reg[chan_reg];

    // Width table write decode
    assign write_en  = accept && (in_data.mode == MODE_WRITE) && (in_data.channel >= 4'd1)
                       && ({1'b0, in_data.channel} <= 5'(CHANNELS));
    assign write_idx = in_data.channel - 4'd1;

    // Next state of the frame timer
    always_comb
    begin
        tick_count_next = tick_count_reg;
        period_next     = period_reg;
        chan_next       = chan_reg;
        running_next    = running_reg;
        pins_next       = pins_reg;
        done            = 1'b0;
        unique case (in_data.mode)
            MODE_TICK:
            begin
                if (running_reg)
                begin
                    if (tick_count_reg >= period_reg)
                    begin
                        tick_count_next = 16'd0;
                        pins_next       = pins_reg & ~pin_bit(chan_reg);
                        if (more_chans)
                        begin
                            chan_next = next_chan[3:0];
                            if (next_width != 16'd0 && !next_width[15])
                            begin
                                period_next = scaled(next_width, scale_reg);
                                pins_next   = pins_next | pin_bit(next_chan[3:0]);
                            end
                            else
                            begin
                                period_next = scaled(EMPTY_SLOT, scale_reg);
                                pins_next   = pins_next & ~pin_bit(next_chan[3:0]);
                            end
                        end
                        else
                        begin
                            running_next = 1'b0;
                            done         = 1'b1;
                        end
                    end
                    else
                    begin
                        tick_count_next = tick_count_reg + 16'd1;
                    end
                end
            end
            MODE_START:
            begin
                if (active_reg != 4'd0)
                begin
                    chan_next       = 4'd0;
                    period_next     = scaled(LEAD_GAP, scale_reg);
                    tick_count_next = 16'd0;
                    pins_next       = '0;
                    running_next    = 1'b1;
                end
            end
            default:
            begin
                // Width writes and the unused mode leave the timer alone
            end
        endcase
    end

    // Build the result transaction from the updated state
    always_comb
    begin
        out_data_next.pins            = pins_next;
        out_data_next.busy_res        = running_next;
        out_data_next.current_channel = running_next ? chan_next : 4'd0;
        out_data_next.frame_done      = done;
    end

    // Advance timer state on each accepted transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_count_reg <= '0;
            period_reg     <= '0;
            chan_reg       <= '0;
            running_reg    <= 1'b0;
            pins_reg       <= '0;
        end
        else if (accept)
        begin
            tick_count_reg <= tick_count_next;
            period_reg     <= period_next;
            chan_reg       <= chan_next;
            running_reg    <= running_next;
            pins_reg       <= pins_next;
        end
    end

    // Hold the width table
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < CHANNELS; k++)
            begin
                widths_reg[k] <= '0;
            end
        end
        else if (write_en)
        begin
            widths_reg[write_idx] <= in_data.width;
        end
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= ACTIVE_CHANNELS_RESET;
            scale_reg  <= CLOCK_SCALE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_ACTIVE_CHANNELS: active_reg <= cfg_data;
                CFG_CLOCK_SCALE:     scale_reg  <= cfg_data[1:0];
                default:             ;
            endcase
        end
    end

    // Result register: load on accept, drop once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_data_reg <= out_data_next;
        end
    end

endmodule
